// ===== sv/tps_pkg.sv =====
// Shared types and constants for the tick priority server.
// No dependencies; every other file refers to it by scoped name.
`default_nettype none

package tps_pkg;

  localparam int ID_W    = 10;
  localparam int RANK_W  = 4;
  localparam int STAMP_W = 16;
  localparam int WAIT_W  = 7;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [ID_W-1:0]   requester_id;
    logic [RANK_W-1:0] rank;
  } item_t;

  typedef struct packed {
    logic              served_valid;
    logic [ID_W-1:0]   served_id;
    logic              dropped;
    logic [WAIT_W-1:0] waiting_count;
  } result_t;

  // Field order gives service order: a plain unsigned less-than on the
  // whole word is rank first, then stamp, then id.
  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [STAMP_W-1:0] stamp;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef struct packed {
    logic   opcode;
    entry_t entry;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/tps_front.sv =====
// Front end: accepts items, keeps the saturating tick counter and stamps arrivals.
// Depends on tps_pkg.
`default_nettype none

module tps_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire tps_pkg::item_t item,
  output logic                cmd_valid,
  input  wire logic           cmd_ready,
  output tps_pkg::cmd_t       cmd
);

  logic [tps_pkg::STAMP_W-1:0] tick_count;
  logic                        xfer;

  assign item_ready = cmd_ready;
  assign cmd_valid  = item_valid;
  assign xfer       = item_valid & cmd_ready;

  // arrivals carry the count as it stands; a tick carries it too and counts
  // itself afterwards, but its stamp is never used
  always_comb begin
    cmd.opcode             = item.opcode;
    cmd.entry.id           = item.requester_id;
    cmd.entry.rank         = item.rank;
    cmd.entry.stamp        = tick_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (xfer && item.opcode == tps_pkg::OP_TICK && tick_count != '1) begin
      tick_count <= tick_count + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tps_queue.sv =====
// Two-entry command queue between front and back end.
// Depends on tps_pkg.
`default_nettype none

module tps_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire tps_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output tps_pkg::cmd_t      pop_cmd
);

  tps_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          push;
  logic          pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/tps_back.sv =====
// Back end: waiting pool in a memory kept packed in slots [0, count),
// scan for the best entry on a tick, result register. Depends on tps_pkg.
`default_nettype none

module tps_back #(
  parameter int POOL_DEPTH = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire tps_pkg::cmd_t cmd,
  output logic               result_valid,
  input  wire logic          result_ready,
  output tps_pkg::result_t   result
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int WW = tps_pkg::WAIT_W;
  localparam int IW = tps_pkg::ID_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  tps_pkg::entry_t mem [POOL_DEPTH];

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   iss_cnt;
  logic            issue;
  logic            rd_ok;
  logic [AW-1:0]   rd_idx;
  tps_pkg::entry_t rd_data;
  logic            have_best;
  tps_pkg::entry_t best_key;
  logic [AW-1:0]   best_idx;
  logic            take_cur;
  logic            last_rd;
  tps_pkg::entry_t sel_key;
  logic [AW-1:0]   sel_idx;
  logic            start;
  logic            pool_full;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  tps_pkg::entry_t mem_wdata;

  assign cnt_m1    = count - CW'(1);
  assign pool_full = (count == CW'(POOL_DEPTH));
  assign cmd_ready = (state == ST_IDLE) && !result_valid;
  assign start     = cmd_valid && cmd_ready;
  assign issue     = (state == ST_SCAN) && (iss_cnt < count);
  assign last_rd   = rd_ok && (rd_idx == cnt_m1[AW-1:0]);
  assign take_cur  = !have_best || (rd_data < best_key);
  assign sel_key   = take_cur ? rd_data : best_key;
  assign sel_idx   = take_cur ? rd_idx : best_idx;

  // one write port: arrival appends at count; end of scan moves the last
  // entry into the slot of the served one
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = cmd.entry;
    if (start && cmd.opcode == tps_pkg::OP_ARRIVE && !pool_full) begin
      mem_we = 1'b1;
    end else if (last_rd) begin
      mem_we    = 1'b1;
      mem_waddr = sel_idx;
      mem_wdata = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[iss_cnt[AW-1:0]];
    rd_idx  <= iss_cnt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rd_ok) begin
      best_key <= sel_key;
      best_idx <= sel_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      iss_cnt      <= '0;
      rd_ok        <= 1'b0;
      have_best    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_ok <= issue;
      if (issue) iss_cnt <= iss_cnt + CW'(1);
      if (result_valid && result_ready) result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (cmd.opcode == tps_pkg::OP_ARRIVE) begin
              result_valid          <= 1'b1;
              result.served_valid   <= 1'b0;
              result.served_id      <= '0;
              result.dropped        <= pool_full;
              if (pool_full) begin
                result.waiting_count <= WW'(count);
              end else begin
                count                <= count + CW'(1);
                result.waiting_count <= WW'(count + CW'(1));
              end
            end else if (count == '0) begin
              result_valid         <= 1'b1;
              result.served_valid  <= 1'b0;
              result.served_id     <= '0;
              result.dropped       <= 1'b0;
              result.waiting_count <= '0;
            end else begin
              iss_cnt   <= '0;
              have_best <= 1'b0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_ok) have_best <= 1'b1;
          if (last_rd) begin
            count                <= cnt_m1;
            result_valid         <= 1'b1;
            result.served_valid  <= 1'b1;
            result.served_id     <= IW'(sel_key.id);
            result.dropped       <= 1'b0;
            result.waiting_count <= WW'(cnt_m1);
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/tick_priority_server_unit.sv =====
// Tick priority server: an arrival, or a tick on an empty pool, gets its result
// registered straight from the back end's idle state; a tick with N > 0 waiting first
// scans the pool memory through its single registered read port, one entry per cycle.
// The back end takes a new item only once the last one is answered and its result taken;
// the 2-entry queue keeps taking items, until full, while the back end works or a result waits.
// Reset (rst, synchronous) empties pool and queue, zeroes the tick counter; memory kept.
`default_nettype none

module tick_priority_server_unit #(
  parameter int POOL_DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire tps_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output tps_pkg::result_t      result
);

  // front -> queue
  logic          f_valid;
  logic          f_ready;
  tps_pkg::cmd_t f_cmd;
  // queue -> back
  logic          b_valid;
  logic          b_ready;
  tps_pkg::cmd_t b_cmd;

  // Front: stamps each arrival with the tick count at its transfer, and
  // counts ticks (saturating). Program order through the queue keeps the
  // stamps consistent with what the back end has served.
  tps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  tps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  // Back: pool kept dense; a serve moves the last entry into the hole.
  tps_back #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (b_valid),
    .cmd_ready    (b_ready),
    .cmd          (b_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== sv/tps_checker.sv =====
// Port-level checks for tick_priority_server_unit, attached by bind.
// Depends on tps_pkg.
`default_nettype none

module tps_checker #(
  parameter int POOL_DEPTH = 64
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_ready,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire tps_pkg::result_t result
);

  localparam logic [tps_pkg::WAIT_W-1:0] FULL_CNT = tps_pkg::WAIT_W'(POOL_DEPTH);

  // an offered item stays offered until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid)
    else $error("item withdrawn before transfer");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.served_valid && result.dropped))
    else $error("serve and drop in one result");

  a_idzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.served_valid |-> result.served_id == '0)
    else $error("served_id not zero without a serve");

  a_dropfull: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.dropped |-> result.waiting_count == FULL_CNT)
    else $error("drop reported with pool not full");

endmodule

bind tick_priority_server_unit tps_checker #(
  .POOL_DEPTH (POOL_DEPTH)
) u_tps_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire

// ===== bench/serve_order_checker.sv =====
// Checker for the tick priority server: watches both channels, keeps its own
// copy of the waiting pool and tick counter, and compares every result.
// Depends on tps_pkg for the item and result layouts.
`timescale 1ns / 100ps

module serve_order_checker #(
  parameter int POOL_SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  tps_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_ready,
  input  tps_pkg::result_t result,
  output int               fails,
  output int               open_count
);

  tps_pkg::entry_t              pool [POOL_SLOTS];
  logic                         live [POOL_SLOTS];
  logic [tps_pkg::STAMP_W-1:0]  tick_now;
  int                           waiting;
  tps_pkg::result_t             due_results [$];
  tps_pkg::result_t             want;

  // rank, then stamp, then id; smaller goes first
  function automatic logic served_sooner(tps_pkg::entry_t a, tps_pkg::entry_t b);
    if (a.rank != b.rank) return a.rank < b.rank;
    if (a.stamp != b.stamp) return a.stamp < b.stamp;
    return a.id < b.id;
  endfunction

  function automatic tps_pkg::result_t advance_pool(tps_pkg::item_t it);
    tps_pkg::result_t r;
    int slot;
    int best;
    r = '0;
    slot = -1;
    best = -1;
    if (it.opcode == tps_pkg::OP_ARRIVE) begin
      for (int i = 0; i < POOL_SLOTS; i++)
        if (!live[i] && slot < 0) slot = i;
      if (slot < 0) begin
        r.dropped = 1'b1;
      end else begin
        pool[slot].rank  = it.rank;
        pool[slot].stamp = tick_now;
        pool[slot].id    = it.requester_id;
        live[slot] = 1'b1;
        waiting++;
      end
    end else begin
      if (tick_now != '1) tick_now++;
      for (int i = 0; i < POOL_SLOTS; i++)
        if (live[i] && (best < 0 || served_sooner(pool[i], pool[best]))) best = i;
      if (best >= 0) begin
        r.served_valid = 1'b1;
        r.served_id    = pool[best].id;
        live[best] = 1'b0;
        waiting--;
      end
    end
    r.waiting_count = tps_pkg::WAIT_W'(waiting);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POOL_SLOTS; i++) live[i] = 1'b0;
      tick_now = '0;
      waiting = 0;
      fails = 0;
      due_results.delete();
    end else begin
      // result side first: nothing accepted at this edge can already be out
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with nothing outstanding: v=%0d id=%0d drop=%0d wait=%0d",
                     $time, result.served_valid, result.served_id, result.dropped,
                     result.waiting_count);
        end else begin
          want = due_results.pop_front();
          if (result.served_valid !== want.served_valid || result.served_id !== want.served_id ||
              result.dropped !== want.dropped ||
              result.waiting_count !== want.waiting_count) begin
            fails++;
            if (fails <= 10) begin
              $write("%0t: mismatch exp v=%0d id=%0d drop=%0d wait=%0d", $time,
                     want.served_valid, want.served_id, want.dropped, want.waiting_count);
              $display(" got v=%0d id=%0d drop=%0d wait=%0d", result.served_valid,
                       result.served_id, result.dropped, result.waiting_count);
            end
          end
        end
      end
      if (item_valid && item_ready) due_results = {due_results, advance_pool(item)};
    end
    open_count = due_results.size();
  end

endmodule

// ===== bench/tb.sv =====
// Top of the tick priority server bench: clock, reset, stimulus and verdict.
// Uses tps_pkg, tick_priority_server_unit and serve_order_checker.
`timescale 1ns / 100ps

module tb;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  tps_pkg::item_t   item = '0;
  logic             result_ready = 1'b0;
  logic             item_ready;
  logic             result_valid;
  tps_pkg::result_t result;
  int               fails;
  int               open_count;

  // Flow-control knobs for the two driving processes.
  logic calm = 1'b0;          // last part: no idling on either side
  logic choke = 1'b0;         // asks the receiver for one long hold-off
  logic sender_idles = 1'b0;  // per-episode: sender may insert gaps
  int   offered = 0;          // item transfers so far

  tick_priority_server_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  serve_order_checker #(.POOL_SLOTS(64)) watch (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fails        (fails),
    .open_count   (open_count)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Hard stop. Budget: ~700 items, each at worst a full 64-entry scan plus
  // a sender gap and a receiver stall, plus the long hold-off once; the
  // limit is ~4x that.
  initial begin
    #5_000_000;
    $display("tick_priority_server_unit test failed");
    $finish;
  end

  // Receiver. Random ready/stall stretches; once, on request, a long
  // hold-off so the 2-deep input queue fills and item_ready drops while the
  // sender keeps valid high.
  initial begin : receiver
    int hold;
    do @(posedge clk); while (rst);
    forever begin
      if (calm) begin
        result_ready <= 1'b1;
        @(posedge clk);
      end else if (choke) begin
        choke = 1'b0;
        result_ready <= 1'b0;
        hold = 0;
        while (hold < 300) begin
          @(posedge clk);
          hold++;
        end
      end else if ($urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // One transfer on the item channel. Called at a rising edge; returns at
  // the edge where the transfer happened, so valid is touched once per step.
  task automatic offer(input logic op, input logic [tps_pkg::ID_W-1:0] id,
                       input logic [tps_pkg::RANK_W-1:0] rk);
    tps_pkg::item_t next;
    next.opcode       = op;
    next.requester_id = id;
    next.rank         = rk;
    if (!calm && sender_idles && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= next;
    do @(posedge clk); while (!item_ready);
    offered++;
  endtask

  task automatic arrive(input logic [tps_pkg::ID_W-1:0] id,
                        input logic [tps_pkg::RANK_W-1:0] rk);
    offer(tps_pkg::OP_ARRIVE, id, rk);
  endtask

  // id and rank are don't-care on a tick; fill them with noise anyway
  task automatic tick();
    offer(tps_pkg::OP_TICK, tps_pkg::ID_W'($urandom), tps_pkg::RANK_W'($urandom));
  endtask

  // ids lean toward the extremes now and then
  function automatic logic [tps_pkg::ID_W-1:0] pick_id();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return tps_pkg::ID_W'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin : stimulus
    int start;
    int ep;
    int pick;
    int n;
    logic [tps_pkg::RANK_W-1:0] rk;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty tick, extremes, rank / stamp / id tie-breaks.
    tick();                       // empty pool, nothing served
    arrive(10'd0, 4'd0);
    arrive(10'd1023, 4'd15);
    arrive(10'h2AA, 4'hA);
    arrive(10'h155, 4'h5);
    tick();                       // rank 0 first
    arrive(10'd5, 4'd5);          // same rank as 0x155, later stamp
    arrive(10'd3, 4'd5);          // same rank and stamp as id 5, smaller id
    tick();
    tick();
    tick();
    tick();
    tick();
    arrive(10'd1023, 4'd0);
    arrive(10'd0, 4'd0);          // equal rank and stamp: id 0 wins
    tick();
    tick();
    tick();                       // drained again

    // Random episodes. The first one floods the pool past full.
    choke = 1'b1;
    start = offered;
    ep = 0;
    while (offered - start < 440) begin
      sender_idles = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (ep == 0 || pick < 4) begin
        // fill to capacity, a few refused, then drain with extra empty ticks
        n = 66 + $urandom_range(0, 4);
        repeat (n) arrive(pick_id(), tps_pkg::RANK_W'($urandom_range(0, 3)));
        repeat (n + 2) tick();
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 1) == 0) arrive(pick_id(), tps_pkg::RANK_W'($urandom));
          else tick();
        end
      end else if (pick < 82) begin
        n = $urandom_range(2, 20);
        repeat (n) arrive(pick_id(), tps_pkg::RANK_W'($urandom));
        repeat (n + $urandom_range(0, 3)) tick();
      end else begin
        // same rank, same stamp: order falls to the id
        n = $urandom_range(2, 8);
        rk = tps_pkg::RANK_W'($urandom);
        repeat (n) arrive(pick_id(), rk);
        repeat (n) tick();
      end
      ep++;
    end

    // Last part, no idling.
    calm = 1'b1;

    // One shared stamp: rank then id decide.
    arrive(10'd700, 4'd7);
    arrive(10'd12, 4'd7);
    arrive(10'd400, 4'd2);
    arrive(10'd1023, 4'd7);
    arrive(10'd0, 4'd15);
    repeat (6) tick();
    repeat (40) begin
      if ($urandom_range(0, 1) == 0) arrive(pick_id(), tps_pkg::RANK_W'($urandom));
      else tick();
    end
    repeat (40) tick();
    item_valid <= 1'b0;

    // wait out the outstanding results
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fails == 0) begin
      $display("tick_priority_server_unit test passed");
    end else begin
      $display("tick_priority_server_unit test failed");
    end
    $finish;
  end

endmodule
